FILE: hw/rtl/wstp_pkg.sv
// ----------------------------------------------------------------------------
// wstp_pkg
// Shared types and constants for the weighted sorted table probe.
// ----------------------------------------------------------------------------
package wstp_pkg;

  localparam int unsigned TableDepth = 1024;
  localparam int unsigned CountW     = 11;

  typedef enum logic [1:0] {
    KIND_CLEAR = 2'd0,
    KIND_ADD   = 2'd1,
    KIND_PROBE = 2'd2,
    KIND_NOP   = 2'd3
  } kind_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] lookup_key;
    logic [15:0] entry_move;
    logic [15:0] entry_weight;
    logic [63:0] random_word;
  } in_word_t;

  typedef struct packed {
    logic [15:0]       chosen_move;
    logic              hit;
    logic [CountW-1:0] entry_count;
    logic [CountW-1:0] position_count;
    logic              overflow;
  } out_word_t;

endpackage

FILE: hw/rtl/weighted_sorted_table_probe.sv
// ----------------------------------------------------------------------------
// weighted_sorted_table_probe
// Key-sorted table of (key, move, weight) entries with weighted probe.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o carry one in_word_t per word.
// Output channel: out_valid_o / out_stall_i, one out_word_t per input word.
// kind 0 clears the table, 1 inserts after all equal or lower keys, 2 probes,
// 3 only reports the counts. One item is worked on at a time; the input is
// stalled from acceptance until the result is taken, and the next word can
// be accepted in the cycle after that.
// Steps per item:
//   clear / nop / dropped add: straight to the result.
//   add: the key is searched twice, the run is walked, and the tail
//        shift moves one entry at a time through the single entry
//        memory port.
//   probe: search, run walk, and for a run of two or more with nonzero
//        total weight a bit-serial modulo of random_word and a pick walk.
// The memory is a single synchronous RAM with registered read data; every
// access is a read, wait, use sequence, so no forwarding is needed.
// Reset empties the table at once (counts to zero, no clearing pass).
// While out_stall_i is high the result holds and no new item is taken.
// ----------------------------------------------------------------------------
module weighted_sorted_table_probe #(
  parameter int unsigned TABLE_DEPTH = wstp_pkg::TableDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  wstp_pkg::in_word_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output wstp_pkg::out_word_t out_data_o
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned NW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CW = wstp_pkg::CountW;
  localparam logic [NW-1:0] DepthN = NW'(TABLE_DEPTH);

  typedef struct packed {
    logic [63:0] key;
    logic [15:0] move;
    logic [15:0] weight;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SRCH, S_SRCH_W, S_SHIFT, S_SHIFT_W, S_RUN, S_RUN_W,
    S_MOD, S_PICK, S_PICK_W, S_DONE, S_OUT
  } state_e;

  entry_t mem [TABLE_DEPTH];
  entry_t rd_q;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  entry_t        wdata;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[raddr];
  end

  state_e state_q;
  wstp_pkg::in_word_t item_q;
  logic [NW-1:0] cnt_q, dist_q;
  logic [NW-1:0] lo_q, hi_q, idx_q, first_q;
  logic          strict_q;
  logic [NW-1:0] run_q;
  logic [31:0]   total_q;
  logic [63:0]   quo_q;
  logic [31:0]   rem_q;
  logic [6:0]    bit_q;
  logic [31:0]   acc_q;
  logic [15:0]   move0_q;
  wstp_pkg::out_word_t res_q;

  logic [NW-1:0] mid;
  logic [NW:0]   lohi;
  logic [32:0]   rem_sh;
  logic [31:0]   acc_n;

  assign lohi   = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid    = lohi[NW:1];
  assign rem_sh = {rem_q, quo_q[63]};
  assign acc_n  = acc_q + 32'(rd_q.weight);

  always_comb begin
    we    = 1'b0;
    waddr = idx_q[AW-1:0];
    wdata = rd_q;
    raddr = idx_q[AW-1:0];
    case (state_q)
      S_SRCH:  raddr = mid[AW-1:0];
      S_SHIFT: raddr = AW'(idx_q - NW'(1));
      S_SHIFT_W: begin
        we = 1'b1;
      end
      S_DONE: begin
        we    = (item_q.kind == wstp_pkg::KIND_ADD) && !res_q.overflow;
        wdata = '{key: item_q.lookup_key, move: item_q.entry_move,
                  weight: item_q.entry_weight};
      end
      default: ;
    endcase
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign out_data_o  = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      dist_q   <= '0;
      item_q   <= '0;
      lo_q     <= '0;
      hi_q     <= '0;
      idx_q    <= '0;
      first_q  <= '0;
      strict_q <= 1'b0;
      run_q    <= '0;
      total_q  <= '0;
      quo_q    <= '0;
      rem_q    <= '0;
      bit_q    <= '0;
      acc_q    <= '0;
      move0_q  <= '0;
      res_q    <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            item_q   <= in_data_i;
            lo_q     <= '0;
            hi_q     <= cnt_q;
            strict_q <= 1'b0;
            case (in_data_i.kind)
              wstp_pkg::KIND_CLEAR: begin
                res_q   <= '0;
                cnt_q   <= '0;
                dist_q  <= '0;
                state_q <= S_DONE;
              end
              wstp_pkg::KIND_ADD: begin
                if (cnt_q >= DepthN) begin
                  res_q   <= '{overflow: 1'b1, default: '0};
                  state_q <= S_DONE;
                end else begin
                  res_q   <= '0;
                  state_q <= S_SRCH;
                end
              end
              wstp_pkg::KIND_PROBE: begin
                res_q   <= '0;
                state_q <= S_SRCH;
              end
              default: begin
                res_q   <= '0;
                state_q <= S_DONE;
              end
            endcase
          end
        end
        S_SRCH: begin
          if (lo_q >= hi_q) begin
            if (!strict_q) begin
              first_q <= lo_q;
              idx_q   <= lo_q;
              run_q   <= '0;
              total_q <= '0;
              state_q <= S_RUN;
            end else begin
              idx_q   <= cnt_q;
              first_q <= lo_q;
              state_q <= S_SHIFT;
            end
          end else begin
            state_q <= S_SRCH_W;
          end
        end
        S_SRCH_W: begin
          if (strict_q ? (rd_q.key <= item_q.lookup_key)
                       : (rd_q.key < item_q.lookup_key)) begin
            lo_q <= mid + NW'(1);
          end else begin
            hi_q <= mid;
          end
          state_q <= S_SRCH;
        end
        S_RUN: begin
          if (idx_q >= cnt_q) begin
            state_q <= S_MOD;
          end else begin
            state_q <= S_RUN_W;
          end
          bit_q <= '0;
          quo_q <= item_q.random_word;
          rem_q <= '0;
        end
        S_RUN_W: begin
          if (rd_q.key == item_q.lookup_key) begin
            if (run_q == '0) begin
              move0_q <= rd_q.move;
            end
            run_q   <= run_q + NW'(1);
            total_q <= total_q + 32'(rd_q.weight);
            idx_q   <= idx_q + NW'(1);
            state_q <= S_RUN;
          end else begin
            state_q <= S_MOD;
          end
        end
        S_MOD: begin
          if (item_q.kind == wstp_pkg::KIND_ADD) begin
            if (run_q == '0) begin
              dist_q <= dist_q + NW'(1);
            end
            lo_q     <= first_q;
            hi_q     <= cnt_q;
            strict_q <= 1'b1;
            state_q  <= S_SRCH;
          end else if (run_q == '0) begin
            state_q <= S_DONE;
          end else if (run_q == NW'(1) || total_q == '0) begin
            res_q   <= '{chosen_move: move0_q, hit: 1'b1, default: '0};
            state_q <= S_DONE;
          end else if (bit_q == 7'd64) begin
            idx_q   <= first_q;
            acc_q   <= '0;
            state_q <= S_PICK;
          end else begin
            if (rem_sh >= {1'b0, total_q}) begin
              rem_q <= 32'(rem_sh - {1'b0, total_q});
            end else begin
              rem_q <= rem_sh[31:0];
            end
            quo_q <= {quo_q[62:0], 1'b0};
            bit_q <= bit_q + 7'd1;
          end
        end
        S_PICK: state_q <= S_PICK_W;
        S_PICK_W: begin
          acc_q <= acc_n;
          idx_q <= idx_q + NW'(1);
          if (rem_q < acc_n) begin
            res_q   <= '{chosen_move: rd_q.move, hit: 1'b1, default: '0};
            state_q <= S_DONE;
          end else begin
            state_q <= S_PICK;
          end
        end
        S_SHIFT: begin
          if (idx_q == first_q) begin
            state_q <= S_DONE;
          end else begin
            state_q <= S_SHIFT_W;
          end
        end
        S_SHIFT_W: begin
          idx_q   <= idx_q - NW'(1);
          state_q <= S_SHIFT;
        end
        S_DONE: begin
          if (item_q.kind == wstp_pkg::KIND_ADD && !res_q.overflow) begin
            cnt_q <= cnt_q + NW'(1);
            res_q <= '{chosen_move: res_q.chosen_move, hit: res_q.hit,
                       entry_count: CW'(cnt_q + NW'(1)),
                       position_count: CW'(dist_q), overflow: res_q.overflow};
          end else begin
            res_q <= '{chosen_move: res_q.chosen_move, hit: res_q.hit,
                       entry_count: CW'(cnt_q),
                       position_count: CW'(dist_q), overflow: res_q.overflow};
          end
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: hw/rtl/wstp_checker.sv
// ----------------------------------------------------------------------------
// wstp_checker
// Port-level checks of the weighted sorted table probe.
// ----------------------------------------------------------------------------
module wstp_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input wstp_pkg::in_word_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input wstp_pkg::out_word_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input open while result pending");

  a_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o && !out_valid_o)
    else $error("item not taken in");

  a_nohit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.hit |-> out_data_o.chosen_move == '0)
    else $error("move without hit");

  a_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.overflow |-> !out_data_o.hit)
    else $error("overflow on probe");

endmodule

bind weighted_sorted_table_probe wstp_checker u_wstp_checker (.*);

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for weighted_sorted_table_probe. Words go in with random gaps
// and come out with random stalls. A behavioral table model predicts each
// result word, and every field is compared with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned Depth = wstp_pkg::TableDepth;
  localparam int unsigned InW   = $bits(wstp_pkg::in_word_t);

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  wstp_pkg::in_word_t  in_data_i;
  logic                out_valid_o;
  logic                out_stall_i;
  wstp_pkg::out_word_t out_data_o;

  weighted_sorted_table_probe u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // shadow table
  logic [63:0] tbl_key[Depth];
  logic [15:0] tbl_move[Depth];
  logic [15:0] tbl_weight[Depth];
  int unsigned tbl_cnt;
  int unsigned tbl_distinct;

  wstp_pkg::out_word_t pending_results[$];
  int          mismatches;
  int          gap_pct;
  int          hold_cycles;
  int          pending_hold;
  logic [63:0] key_pool[8];

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #200ms;
    $display("TEST FAILED");
    $finish;
  end

  function automatic wstp_pkg::out_word_t predict_table(wstp_pkg::in_word_t w);
    wstp_pkg::out_word_t r;
    int unsigned lo, hi, mid, pos, run;
    logic [63:0] total, pick, acc;
    r = '0;
    case (wstp_pkg::kind_e'(w.kind))
      wstp_pkg::KIND_CLEAR: begin
        tbl_cnt = 0;
        tbl_distinct = 0;
      end
      wstp_pkg::KIND_ADD: begin
        if (tbl_cnt >= Depth) begin
          r.overflow = 1'b1;
        end else begin
          lo = 0;
          hi = tbl_cnt;
          while (lo < hi) begin
            mid = (lo + hi) / 2;
            if (tbl_key[mid] <= w.lookup_key) lo = mid + 1;
            else hi = mid;
          end
          pos = lo;
          if (pos == 0 || tbl_key[pos-1] != w.lookup_key) tbl_distinct++;
          for (int i = tbl_cnt; i > pos; i--) begin
            tbl_key[i] = tbl_key[i-1];
            tbl_move[i] = tbl_move[i-1];
            tbl_weight[i] = tbl_weight[i-1];
          end
          tbl_key[pos] = w.lookup_key;
          tbl_move[pos] = w.entry_move;
          tbl_weight[pos] = w.entry_weight;
          tbl_cnt++;
        end
      end
      wstp_pkg::KIND_PROBE: begin
        lo = 0;
        hi = tbl_cnt;
        while (lo < hi) begin
          mid = (lo + hi) / 2;
          if (tbl_key[mid] < w.lookup_key) lo = mid + 1;
          else hi = mid;
        end
        run = 0;
        while (lo + run < tbl_cnt && tbl_key[lo+run] == w.lookup_key) run++;
        if (run > 0) begin
          r.hit = 1'b1;
          r.chosen_move = tbl_move[lo];
          total = 0;
          for (int i = 0; i < run; i++) total += tbl_weight[lo+i];
          if (run > 1 && total != 0) begin
            pick = w.random_word % total;
            acc = 0;
            for (int i = 0; i < run; i++) begin
              acc += tbl_weight[lo+i];
              if (pick < acc) begin
                r.chosen_move = tbl_move[lo+i];
                break;
              end
            end
          end
        end
      end
      default: ;
    endcase
    r.entry_count = tbl_cnt[wstp_pkg::CountW-1:0];
    r.position_count = tbl_distinct[wstp_pkg::CountW-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatches++;
    $display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
  endtask

  task automatic send_word(wstp_pkg::kind_e k, logic [63:0] key, logic [15:0] mv,
                           logic [15:0] wt, logic [63:0] rnd);
    wstp_pkg::in_word_t w;
    w.kind = k;
    w.lookup_key = key;
    w.entry_move = mv;
    w.entry_weight = wt;
    w.random_word = rnd;
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      in_data_i <= InW'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_results = {pending_results, predict_table(w)};
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    in_data_i <= InW'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] pool_key();
    return key_pool[$urandom_range(7)];
  endfunction

  // result checker
  always @(posedge clk_i) begin
    wstp_pkg::out_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected word", 64'(out_data_o), 64'h0);
      end else begin
        want = pending_results.pop_front();
        if (out_data_o.chosen_move !== want.chosen_move)
          report_mismatch("chosen_move", 64'(out_data_o.chosen_move),
                          64'(want.chosen_move));
        if (out_data_o.hit !== want.hit)
          report_mismatch("hit", 64'(out_data_o.hit), 64'(want.hit));
        if (out_data_o.entry_count !== want.entry_count)
          report_mismatch("entry_count", 64'(out_data_o.entry_count),
                          64'(want.entry_count));
        if (out_data_o.position_count !== want.position_count)
          report_mismatch("position_count", 64'(out_data_o.position_count),
                          64'(want.position_count));
        if (out_data_o.overflow !== want.overflow)
          report_mismatch("overflow", 64'(out_data_o.overflow), 64'(want.overflow));
      end
    end
  end

  // receiver stall
  always @(negedge clk_i) begin
    if (pending_hold > 0) begin
      hold_cycles = pending_hold;
      pending_hold = 0;
    end
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < gap_pct);
    end
  end

  task automatic test_directed();
    send_word(wstp_pkg::KIND_PROBE, 64'h0, 16'h1, 16'h1, 64'h0);
    send_word(wstp_pkg::KIND_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 16'hFFFF, 64'h0);
    send_word(wstp_pkg::KIND_ADD, 64'h0, 16'h0, 16'h0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_word(wstp_pkg::KIND_PROBE, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0, 16'h0,
              64'hFFFF_FFFF_FFFF_FFFF);
    send_word(wstp_pkg::KIND_PROBE, 64'h0, 16'h0, 16'h0, 64'h5);
    send_word(wstp_pkg::KIND_ADD, 64'h0, 16'h22, 16'h0, 64'h0);
    send_word(wstp_pkg::KIND_ADD, 64'h0, 16'h33, 16'h0, 64'h0);
    send_word(wstp_pkg::KIND_PROBE, 64'h0, 16'h0, 16'h0, 64'h1234);
    send_word(wstp_pkg::KIND_ADD, 64'h77, 16'hA1, 16'h1, 64'h0);
    send_word(wstp_pkg::KIND_ADD, 64'h77, 16'hA2, 16'h2, 64'h0);
    send_word(wstp_pkg::KIND_ADD, 64'h77, 16'hA3, 16'hFFFF, 64'h0);
    for (int i = 0; i < 4; i++)
      send_word(wstp_pkg::KIND_PROBE, 64'h77, 16'h0, 16'h0, 64'(i));
    send_word(wstp_pkg::KIND_PROBE, 64'h77, 16'h0, 16'h0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_word(wstp_pkg::KIND_NOP, rand64(), 16'hFFFF, 16'hFFFF, rand64());
    send_word(wstp_pkg::KIND_PROBE, 64'h76, 16'h0, 16'h0, 64'h0);
    send_word(wstp_pkg::KIND_CLEAR, rand64(), 16'hFFFF, 16'hFFFF, rand64());
    send_word(wstp_pkg::KIND_PROBE, 64'h77, 16'h0, 16'h0, 64'h0);
  endtask

  task automatic test_overflow();
    send_word(wstp_pkg::KIND_CLEAR, 64'h0, 16'h0, 16'h0, 64'h0);
    gap_pct = 0;
    for (int i = 0; i < Depth + 3; i++)
      send_word(wstp_pkg::KIND_ADD, 64'({$urandom_range(40), 2'b0}), 16'($urandom),
                16'($urandom), 64'h0);
    gap_pct = 24;
    send_word(wstp_pkg::KIND_PROBE, 64'h8, 16'h0, 16'h0, rand64());
    send_word(wstp_pkg::KIND_NOP, 64'h0, 16'h0, 16'h0, 64'h0);
    send_word(wstp_pkg::KIND_CLEAR, 64'h0, 16'h0, 16'h0, 64'h0);
  endtask

  task automatic test_backpressure();
    pending_hold = 300;
    for (int i = 0; i < 6; i++)
      send_word(wstp_pkg::KIND_ADD, pool_key(), 16'($urandom), 16'($urandom_range(3)),
                64'h0);
    drain_results();
    send_word(wstp_pkg::KIND_PROBE, pool_key(), 16'h0, 16'h0, rand64());
  endtask

  task automatic test_random(int n);
    int unsigned sel;
    logic [15:0] wt;
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) gap_pct = 0;
      if (i == n / 2 + 150) gap_pct = 24;
      sel = $urandom_range(99);
      wt = ($urandom_range(3) == 0) ? 16'h0 :
           ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(5));
      if (sel < 2)
        send_word(wstp_pkg::KIND_CLEAR, rand64(), 16'($urandom), 16'($urandom),
                  rand64());
      else if (sel < 4)
        send_word(wstp_pkg::KIND_NOP, rand64(), 16'($urandom), 16'($urandom), rand64());
      else if (sel < 50)
        send_word(wstp_pkg::KIND_ADD, ($urandom_range(9) == 0) ? rand64() : pool_key(),
                  16'($urandom), wt, rand64());
      else
        send_word(wstp_pkg::KIND_PROBE, ($urandom_range(9) == 0) ? rand64() : pool_key(),
                  16'($urandom), 16'($urandom), rand64());
    end
  endtask

  initial begin
    mismatches = 0;
    gap_pct = 24;
    hold_cycles = 0;
    pending_hold = 0;
    tbl_cnt = 0;
    tbl_distinct = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    key_pool[0] = 64'h0;
    key_pool[1] = 64'hFFFF_FFFF_FFFF_FFFF;
    for (int i = 2; i < 8; i++) key_pool[i] = rand64();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_overflow();
    test_backpressure();
    test_random(800);
    test_random(40);
    drain_results();
    repeat (200) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
